### design/cflru_pkg.sv
// Shared constants, types and sequencer states for the clean-first LRU block cache.
// Used by cflru_block_cache_policy; no dependencies.
`default_nettype none
package cflru_pkg;
  localparam int ENTRIES    = 256;
  localparam int KEY_BITS   = 64;
  localparam int BLOCK_BITS = 48;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int IN_W       = ((KEY_BITS + BLOCK_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_W      = ((KEY_BITS + BLOCK_BITS + 2 + 7) / 8) * 8;
  localparam int ENT_W      = KEY_BITS + BLOCK_BITS + 1;
  localparam logic [7:0] CW_RESET = 8'd42;

  typedef enum logic [0:0] {
    REG_POLICY       = 1'b0,
    REG_CLEAN_WINDOW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  dirty;
    logic [BLOCK_BITS-1:0] block;
    logic [KEY_BITS-1:0]   tag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_MISS, ST_WALK, ST_WALK_CHK, ST_EV_RD, ST_EVICT,
    ST_MN0, ST_MN1, ST_MN2, ST_OUT
  } state_t;
endpackage
`default_nettype wire

### design/cflru_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module cflru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/cflru_block_cache_policy.sv
// Top level of the clean-first LRU block cache: sequencer, registers and memories.
// Depends on cflru_pkg and cflru_ram.
//
// Channel  Beat fields (low bit up)                      Handshake
// in_      key, block number, is_write                   in_tvalid / in_tready
// out_     hit, writeback, evicted_key, evicted_block    out_tvalid / out_tready
// cfg_     index 0 policy, index 1 clean_window          cfg_we, no wait
//
// One access at a time; the tag search reads one entry per cycle. A miss into a free
// slot is written there directly; an eviction runs the clean-first walk when policy is 0,
// then reads the victim and updates the recency list.
// Reset is synchronous; the memories need no clearing. A waiting result
// holds the sequencer in its final state until out_tready.
`default_nettype none
module cflru_block_cache_policy
  import cflru_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // key, block number, is_write, zero fill
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata,  // hit, writeback, evicted_key, evicted_block, zero fill
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [7:0]       cfg_wdata
);
  state_t state_r, state_nxt;
  logic policy_r;
  logic [7:0] cw_r;
  logic [CNT_W-1:0] used_r, used_nxt, i_r, i_nxt;
  logic [IDX_W-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt, cur_r, cur_nxt, pidx_r, pidx_nxt;
  logic pend_r, pend_nxt;
  logic [7:0] j_r, j_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [BLOCK_BITS-1:0] blk_r;
  logic wr_r;
  logic res_hit_r, res_hit_nxt, res_wb_r, res_wb_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic [BLOCK_BITS-1:0] res_blk_r, res_blk_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic ent_we, nw_we, ol_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr, nw_waddr, nw_wdata, ol_waddr, ol_wdata, lnk_raddr;
  logic [IDX_W-1:0] nw_q, ol_q;
  entry_t ent_wdata, ent_q;
  logic [ENT_W-1:0] ent_q_raw;

  assign ent_q = entry_t'(ent_q_raw);

  cflru_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entry (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_q_raw));
  cflru_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_newer (
    .clk(clk), .we(nw_we), .waddr(nw_waddr), .wdata(nw_wdata),
    .raddr(lnk_raddr), .rdata(nw_q));
  cflru_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_older (
    .clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
    .raddr(lnk_raddr), .rdata(ol_q));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r; used_nxt = used_r; i_nxt = i_r;
    newest_nxt = newest_r; oldest_nxt = oldest_r; slot_nxt = slot_r;
    cur_nxt = cur_r; pidx_nxt = pidx_r; pend_nxt = pend_r; j_nxt = j_r;
    res_hit_nxt = res_hit_r; res_wb_nxt = res_wb_r;
    res_key_nxt = res_key_r; res_blk_nxt = res_blk_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;
    ent_we = 1'b0; ent_waddr = slot_r; ent_wdata = '{dirty: wr_r, block: blk_r, tag: key_r};
    ent_raddr = i_r[IDX_W-1:0];
    nw_we = 1'b0; nw_waddr = newest_r; nw_wdata = slot_r;
    ol_we = 1'b0; ol_waddr = slot_r; ol_wdata = newest_r;
    lnk_raddr = slot_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SEARCH; i_nxt = '0; pend_nxt = 1'b0;
          res_hit_nxt = 1'b0; res_wb_nxt = 1'b0; res_key_nxt = '0; res_blk_nxt = '0;
        end
      end
      ST_SEARCH: begin
        if (pend_r && ent_q.tag == key_r) begin
          res_hit_nxt = 1'b1; slot_nxt = pidx_r;
          ent_we = 1'b1; ent_waddr = pidx_r;
          ent_wdata = '{dirty: ent_q.dirty | wr_r, block: ent_q.block, tag: ent_q.tag};
          state_nxt = ST_MN0;
        end else if (i_r < used_r) begin
          pend_nxt = 1'b1; pidx_nxt = i_r[IDX_W-1:0]; i_nxt = i_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        if (used_r < CNT_W'(ENTRIES)) begin
          ent_we = 1'b1; ent_waddr = used_r[IDX_W-1:0];
          if (used_r == '0) begin
            oldest_nxt = used_r[IDX_W-1:0];
          end else begin
            ol_we = 1'b1; ol_waddr = used_r[IDX_W-1:0]; ol_wdata = newest_r;
            nw_we = 1'b1; nw_waddr = newest_r; nw_wdata = used_r[IDX_W-1:0];
          end
          newest_nxt = used_r[IDX_W-1:0];
          used_nxt = used_r + 1'b1;
          state_nxt = ST_OUT;
        end else if (policy_r) begin
          slot_nxt = oldest_r; state_nxt = ST_EV_RD;
        end else begin
          cur_nxt = oldest_r; j_nxt = '0; state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        ent_raddr = cur_r; lnk_raddr = cur_r; state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (!ent_q.dirty) begin
          slot_nxt = cur_r; state_nxt = ST_EV_RD;
        end else if (cur_r == newest_r || j_r == cw_r) begin
          slot_nxt = oldest_r; state_nxt = ST_EV_RD;
        end else begin
          cur_nxt = nw_q; j_nxt = j_r + 1'b1; state_nxt = ST_WALK;
        end
      end
      ST_EV_RD: begin
        ent_raddr = slot_r; state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        res_wb_nxt = ent_q.dirty;
        res_key_nxt = ent_q.dirty ? ent_q.tag : '0;
        res_blk_nxt = ent_q.dirty ? ent_q.block : '0;
        ent_we = 1'b1;
        state_nxt = ST_MN0;
      end
      ST_MN0: begin
        state_nxt = (slot_r == newest_r) ? ST_OUT : ST_MN1;
      end
      ST_MN1: begin
        if (slot_r == oldest_r) begin
          oldest_nxt = nw_q;
        end else begin
          nw_we = 1'b1; nw_waddr = ol_q; nw_wdata = nw_q;
          ol_we = 1'b1; ol_waddr = nw_q; ol_wdata = ol_q;
        end
        state_nxt = ST_MN2;
      end
      ST_MN2: begin
        ol_we = 1'b1; nw_we = 1'b1; newest_nxt = slot_r; state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = OUT_W'({res_blk_r, res_key_r, res_wb_r, res_hit_r});
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; policy_r <= 1'b0; cw_r <= CW_RESET;
      used_r <= '0; newest_r <= '0; oldest_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt;
      newest_r <= newest_nxt; oldest_r <= oldest_nxt; out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_POLICY:       policy_r <= cfg_wdata[0];
          REG_CLEAN_WINDOW: cw_r <= cfg_wdata;
          default:          cw_r <= cw_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; slot_r <= slot_nxt; cur_r <= cur_nxt; pidx_r <= pidx_nxt;
    pend_r <= pend_nxt; j_r <= j_nxt;
    res_hit_r <= res_hit_nxt; res_wb_r <= res_wb_nxt;
    res_key_r <= res_key_nxt; res_blk_r <= res_blk_nxt; out_data_r <= out_data_nxt;
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata[KEY_BITS-1:0];
      blk_r <= in_tdata[KEY_BITS +: BLOCK_BITS];
      wr_r  <= in_tdata[KEY_BITS+BLOCK_BITS];
    end
  end

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES)) else $error("slot count beyond capacity");
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_SEARCH) else $error("accept did not start search");
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !(res_hit_r && res_wb_r)) else $error("writeback on a hit");
`endif
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for cflru_block_cache_policy: random and directed cache accesses
// are checked against an in-bench recency-list predictor. Depends on cflru_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top
  import cflru_pkg::*;
();

  class cache_scoreboard;
    typedef struct packed {
      logic                  writeback;
      logic                  hit;
      logic [KEY_BITS-1:0]   ev_key;
      logic [BLOCK_BITS-1:0] ev_block;
    } access_result_t;

    bit                    lru_only;
    bit [7:0]              window;
    bit [KEY_BITS-1:0]     tags[ENTRIES];
    bit [BLOCK_BITS-1:0]   blocks[ENTRIES];
    bit                    dirty[ENTRIES];
    int                    newer[ENTRIES];
    int                    older[ENTRIES];
    int                    newest, oldest, used;
    access_result_t        pending[$];
    int                    errors;

    function new();
      lru_only = 0;
      window = 8'd42;
      newest = 0;
      oldest = 0;
      used = 0;
      errors = 0;
      foreach (dirty[i]) dirty[i] = 0;
    endfunction

    function void to_front(int s);
      if (s == newest) return;
      if (s == oldest) begin
        oldest = newer[s];
      end else begin
        newer[older[s]] = newer[s];
        older[newer[s]] = older[s];
      end
      older[s] = newest;
      newer[newest] = s;
      newest = s;
    endfunction

    function int choose_victim();
      int s;
      s = oldest;
      if (lru_only) return oldest;
      for (int i = 0; i <= window; i++) begin
        if (!dirty[s]) return s;
        if (s == newest) break;
        s = newer[s];
      end
      return oldest;
    endfunction

    function void note_access(bit [KEY_BITS-1:0] k, bit [BLOCK_BITS-1:0] b, bit wr);
      access_result_t r;
      int s;
      r = '0;
      for (int i = 0; i < used; i++) begin
        if (tags[i] == k) begin
          if (wr) dirty[i] = 1;
          to_front(i);
          r.hit = 1;
          pending.push_back(r);
          return;
        end
      end
      if (used < ENTRIES) begin
        s = used;
        if (used == 0) begin
          newest = s;
          oldest = s;
        end else begin
          older[s] = newest;
          newer[newest] = s;
          newest = s;
        end
        used++;
      end else begin
        s = choose_victim();
        if (dirty[s]) begin
          r.writeback = 1;
          r.ev_key = tags[s];
          r.ev_block = blocks[s];
        end
        to_front(s);
      end
      tags[s] = k;
      blocks[s] = b;
      dirty[s] = wr;
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] d);
      access_result_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.hit) report($sformatf("hit got %b want %b", d[0], e.hit));
      if (d[1] !== e.writeback)
        report($sformatf("writeback got %b want %b", d[1], e.writeback));
      if (d[2 +: KEY_BITS] !== e.ev_key)
        report($sformatf("evicted_key got %h want %h", d[2 +: KEY_BITS], e.ev_key));
      if (d[2 + KEY_BITS +: BLOCK_BITS] !== e.ev_block)
        report($sformatf("evicted_block got %h want %h",
                         d[2 + KEY_BITS +: BLOCK_BITS], e.ev_block));
    endtask
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_tvalid = 0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we = 0;
  logic [0:0]       cfg_index = REG_POLICY;
  logic [7:0]       cfg_wdata = '0;

  cache_scoreboard  sb = new();
  longint           cycles = 0;
  bit               sink_on = 0;
  bit               quiet_sink = 0;

  always #5 clk = ~clk;

  cflru_block_cache_policy u_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 12000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_sink || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int g;
    @(posedge clk);
    forever begin
      if (!sink_on) begin
        @(posedge clk);
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_tready <= 1;
          @(posedge clk);
        end else begin
          out_tready <= 0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send(bit [KEY_BITS-1:0] k, bit [BLOCK_BITS-1:0] b, bit wr);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= IN_W'({wr, b, k});
    do @(posedge clk); while (!in_tready);
    sb.note_access(k, b, wr);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [7:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_POLICY) sb.lru_only = v[0];
    else sb.window = v;
    @(posedge clk);
  endtask

  function automatic bit [KEY_BITS-1:0] rand_key(int pool);
    bit [KEY_BITS-1:0] k;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    k = {2'($urandom_range(0, 3)), 30'h0, 32'($urandom_range(0, pool - 1))};
    return k ^ 64'h5a5a_0000_0000_0000;
  endfunction

  task automatic random_phase(int n, int pool);
    for (int i = 0; i < n; i++)
      send(rand_key(pool), BLOCK_BITS'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    sink_on = 1;
    quiet_sink = 0;
    send('0, '0, 0);
    send('1, '1, 1);
    send('0, '1, 1);
    send('1, '0, 0);
    send(64'h8000_0000_0000_0001, 48'h8000_0000_0001, 0);
    send(64'h7fff_ffff_ffff_fffe, 48'h7fff_ffff_fffe, 1);
    for (int i = 0; i < 260; i++)
      send(64'h1000 + i, 48'h100 + i, (i % 3) != 0);
    send('1, 48'h123, 0);
    drain();
    write_reg(REG_POLICY, 8'h01);
    write_reg(REG_CLEAN_WINDOW, 8'd0);
    random_phase(300, 400);
    drain();
    write_reg(REG_POLICY, 8'h00);
    random_phase(300, 400);
    drain();
    write_reg(REG_CLEAN_WINDOW, 8'd255);
    random_phase(350, 420);
    drain();
    write_reg(REG_CLEAN_WINDOW, 8'd5);
    random_phase(350, 380);
    drain();
    write_reg(REG_POLICY, 8'hfe);
    write_reg(REG_CLEAN_WINDOW, 8'd42);
    random_phase(100, 300);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
